>>> rtl/core/mie_pkg.sv
`timescale 1ns / 1ps

package mie_pkg;

   localparam int WORD_BITS  = 31;
   // Bezout coefficients stay within +/- modulus: word plus sign plus headroom
   localparam int COEF_BITS  = WORD_BITS + 2;
   // shift count of the aligned divisor never exceeds WORD_BITS-1
   localparam int SHIFT_BITS = $clog2(WORD_BITS);

   typedef struct packed {
      logic [WORD_BITS-1:0] value;
      logic [WORD_BITS-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] inverse;
      logic [WORD_BITS-1:0] divisor;
      logic                 not_coprime;
   } rsp_type;

   typedef struct packed {
      logic                        done;
      logic [WORD_BITS-1:0]        gcd;
      logic signed [COEF_BITS-1:0] coef;
   } euc_status_type;

   typedef enum logic [1:0] {
      EU_IDLE,
      EU_CHECK,
      EU_DIV
   } euc_state_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } top_state_type;

endpackage

>>> rtl/core/mie_euclid.sv
`timescale 1ns / 1ps

module mie_euclid import mie_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  req_type        req_data,
   output euc_status_type status
);

   euc_state_type               state_ff, state_in;
   logic [WORD_BITS-1:0]        rp_ff, rp_in;
   logic [WORD_BITS-1:0]        rc_ff, rc_in;
   logic signed [COEF_BITS-1:0] sp_ff, sp_in;
   logic signed [COEF_BITS-1:0] sc_ff, sc_in;
   logic [WORD_BITS-1:0]        d_ff, d_in;
   logic signed [COEF_BITS-1:0] t_ff, t_in;
   logic [SHIFT_BITS-1:0]       k_ff, k_in;
   logic                        align_ff, align_in;
   logic                        done_ff, done_in;

   logic [WORD_BITS:0]          dbl;
   logic                        grow;
   logic [WORD_BITS:0]          diff;
   logic                        fits;
   logic [WORD_BITS-1:0]        rem;
   logic signed [COEF_BITS-1:0] sacc;

   // shared subtract unit: partial remainder minus aligned divisor,
   // coefficient minus aligned coefficient
   always_comb begin
      dbl  = {d_ff, 1'b0};
      grow = align_ff && (dbl <= {1'b0, rp_ff});
      diff = {1'b0, rp_ff} - {1'b0, d_ff};
      fits = !diff[WORD_BITS];
      rem  = fits ? diff[WORD_BITS-1:0] : rp_ff;
      sacc = fits ? (sp_ff - t_ff) : sp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EU_IDLE;
         done_ff  <= 1'b0;
         align_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         align_ff <= align_in;
         k_ff     <= k_in;
      end
      rp_ff <= rp_in;
      rc_ff <= rc_in;
      sp_ff <= sp_in;
      sc_ff <= sc_in;
      d_ff  <= d_in;
      t_ff  <= t_in;
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      align_in = align_ff;
      k_in     = k_ff;
      rp_in    = rp_ff;
      rc_in    = rc_ff;
      sp_in    = sp_ff;
      sc_in    = sc_ff;
      d_in     = d_ff;
      t_in     = t_ff;
      unique case (state_ff)
         EU_IDLE: begin
            if (load) begin
               rp_in    = req_data.value;
               rc_in    = req_data.modulus;
               sp_in    = COEF_BITS'(1);
               sc_in    = '0;
               state_in = EU_CHECK;
            end
         end
         EU_CHECK: begin
            if (rc_ff == '0) begin
               done_in  = 1'b1;
               state_in = EU_IDLE;
            end else begin
               d_in     = rc_ff;
               t_in     = sc_ff;
               k_in     = '0;
               align_in = 1'b1;
               state_in = EU_DIV;
            end
         end
         EU_DIV: begin
            if (grow) begin
               d_in = dbl[WORD_BITS-1:0];
               t_in = t_ff <<< 1;
               k_in = k_ff + SHIFT_BITS'(1);
            end else begin
               align_in = 1'b0;
               if (k_ff == '0) begin
                  // quotient step complete: rotate remainder and coefficient pairs
                  rp_in = rc_ff;
                  rc_in = rem;
                  sp_in = sc_ff;
                  sc_in = sacc;
                  if (rem == '0) begin
                     done_in  = 1'b1;
                     state_in = EU_IDLE;
                  end else begin
                     d_in     = rem;
                     t_in     = sacc;
                     align_in = 1'b1;
                  end
               end else begin
                  rp_in = rem;
                  sp_in = sacc;
                  d_in  = d_ff >> 1;
                  t_in  = t_ff >>> 1;
                  k_in  = k_ff - SHIFT_BITS'(1);
               end
            end
         end
         default: state_in = EU_IDLE;
      endcase
   end

   assign status.done = done_ff;
   assign status.gcd  = rp_ff;
   assign status.coef = sp_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == EU_IDLE)
      else $error("done raised while iterating");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == EU_DIV |-> (rc_ff != '0) && (d_ff != '0))
      else $error("division by zero remainder");

   a_align: assert property (@(posedge clock) disable iff (reset)
      state_ff == EU_DIV |-> (d_ff >> k_ff) == rc_ff)
      else $error("aligned divisor lost its bits");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (load && state_ff == EU_IDLE) |=> state_ff == EU_CHECK)
      else $error("new transaction not started");

endmodule

>>> rtl/core/modular_inverse_ext_euclid_unit.sv
`timescale 1ns / 1ps

// channel    ports                          direction  handshake
// request    start, busy, req_data          in         start && !busy
// response   rsp_strobe, rsp_data           out        rsp_strobe, one cycle
//
// One transaction at a time: a setup step, then for each Euclid quotient step
// an alignment phase that doubles the divisor and a phase that subtracts and
// halves it back, then the reduction and the output register. The shared
// shift/subtract unit carries out every quotient step, bit by bit.
// Reset clears the sequencer and the strobe. The receiver cannot stall; busy
// falls in the cycle the result is strobed.

module modular_inverse_ext_euclid_unit import mie_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   top_state_type        state_ff, state_in;
   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                        accept;
   euc_status_type              status;
   logic [COEF_BITS-1:0]        mext;
   logic                        neg;
   logic signed [COEF_BITS-1:0] op;
   logic signed [COEF_BITS-1:0] res;
   logic [WORD_BITS-1:0]        reduced;
   logic                        coprime;

   assign accept = start && (state_ff == ST_IDLE);

   mie_euclid u_euclid (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .req_data (req_data),
      .status   (status)
   );

   // bring the coefficient into 0 .. modulus-1 with one add
   always_comb begin
      mext    = {2'b00, modulus_ff};
      neg     = status.coef[COEF_BITS-1];
      op      = neg ? $signed(mext) : -$signed(mext);
      res     = status.coef + op;
      reduced = (neg || !res[COEF_BITS-1]) ? res[WORD_BITS-1:0]
                                           : status.coef[WORD_BITS-1:0];
      coprime = (status.gcd == WORD_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      modulus_ff  <= modulus_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      modulus_in    = modulus_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               modulus_in = req_data.modulus;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.done) begin
               rsp_strobe_in           = 1'b1;
               rsp_data_in.divisor     = status.gcd;
               rsp_data_in.not_coprime = !coprime;
               rsp_data_in.inverse     = (coprime && modulus_ff != '0) ? reduced : '0;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_strobe_after_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_RUN))
      else $error("result without a transaction");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == ST_IDLE)
      else $error("still busy at result");

   a_no_inverse: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_data_ff.not_coprime) |-> rsp_data_ff.inverse == '0)
      else $error("inverse given for non-coprime operands");

endmodule
